[src/mmc_spi_block_sequencer_macros.svh]
// Assertion macros shared by the sequencer checker.
// No dependencies; included by files that assert.
`ifndef MMC_SPI_BLOCK_SEQUENCER_MACROS_SVH
`define MMC_SPI_BLOCK_SEQUENCER_MACROS_SVH

// same-cycle implication, quiet during reset
`define MSBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define MSBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/msbs_pkg.sv]
// Types, phase codes and byte constants for the SPI-mode card sequencer.
// No dependencies.
package msbs_pkg;

   localparam int OPCODE_W   = 2;
   localparam int BLOCK_W    = 16;
   localparam int BYTE_W     = 8;
   localparam int ERROR_W    = 3;
   localparam int PHASE_W    = 5;
   localparam int COUNT_W    = 10;
   localparam int WAIT_W     = 16;
   localparam int RETRY_W    = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int BLOCK_BYTES = 512;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

   localparam logic [OPCODE_W-1:0] OP_INIT     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_WRITE    = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_EXCHANGE = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_RESPONSE_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_RETRY_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAKE_CLOCK_BYTES = 2'd2;

   localparam logic [ERROR_W-1:0] ERR_OK          = 3'd0;
   localparam logic [ERROR_W-1:0] ERR_NO_IDLE     = 3'd1;
   localparam logic [ERROR_W-1:0] ERR_RETRY_LIMIT = 3'd2;
   localparam logic [ERROR_W-1:0] ERR_CMD_TIMEOUT = 3'd3;
   localparam logic [ERROR_W-1:0] ERR_NO_TOKEN    = 3'd4;
   localparam logic [ERROR_W-1:0] ERR_REJECTED    = 3'd5;

   localparam logic [PHASE_W-1:0] PH_IDLE  = 5'd0;
   localparam logic [PHASE_W-1:0] PH_WAKE  = 5'd1;
   localparam logic [PHASE_W-1:0] PH_CMD0  = 5'd2;
   localparam logic [PHASE_W-1:0] PH_R0    = 5'd3;
   localparam logic [PHASE_W-1:0] PH_CMD1  = 5'd4;
   localparam logic [PHASE_W-1:0] PH_R1    = 5'd5;
   localparam logic [PHASE_W-1:0] PH_GAP   = 5'd6;
   localparam logic [PHASE_W-1:0] PH_CMD16 = 5'd7;
   localparam logic [PHASE_W-1:0] PH_R16   = 5'd8;
   localparam logic [PHASE_W-1:0] PH_CMD17 = 5'd9;
   localparam logic [PHASE_W-1:0] PH_R17   = 5'd10;
   localparam logic [PHASE_W-1:0] PH_TOKW  = 5'd11;
   localparam logic [PHASE_W-1:0] PH_RDATA = 5'd12;
   localparam logic [PHASE_W-1:0] PH_RCRC  = 5'd13;
   localparam logic [PHASE_W-1:0] PH_RTAIL = 5'd14;
   localparam logic [PHASE_W-1:0] PH_CMD24 = 5'd15;
   localparam logic [PHASE_W-1:0] PH_R24   = 5'd16;
   localparam logic [PHASE_W-1:0] PH_WTOK  = 5'd17;
   localparam logic [PHASE_W-1:0] PH_WDATA = 5'd18;
   localparam logic [PHASE_W-1:0] PH_WCRC  = 5'd19;
   localparam logic [PHASE_W-1:0] PH_WRESP = 5'd20;

   localparam logic [BYTE_W-1:0] CMD0_CODE   = 8'h40;
   localparam logic [BYTE_W-1:0] CMD0_CRC    = 8'h95;
   localparam logic [BYTE_W-1:0] CMD1_CODE   = 8'h41;
   localparam logic [BYTE_W-1:0] CMD16_CODE  = 8'h50;
   localparam logic [BYTE_W-1:0] CMD17_CODE  = 8'h51;
   localparam logic [BYTE_W-1:0] CMD24_CODE  = 8'h58;
   localparam logic [BYTE_W-1:0] LEN_HI_BYTE = 8'h02;
   localparam logic [BYTE_W-1:0] IDLE_BYTE   = 8'hFF;
   localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;
   localparam logic [BYTE_W-1:0] R1_IDLE     = 8'h01;
   localparam logic [BYTE_W-1:0] R1_READY    = 8'h00;
   localparam logic [BYTE_W-1:0] DATA_TOKEN  = 8'hFE;
   localparam logic [3:0]        RESP_MASKED_OK = 4'h5;

   localparam logic [COUNT_W-1:0] CMD_BYTES = 10'd6;
   localparam logic [COUNT_W-1:0] CRC_BYTES = 10'd2;
   localparam logic [COUNT_W-1:0] DATA_BYTES = COUNT_W'(BLOCK_BYTES);

   typedef struct packed {
      logic [WAIT_W-1:0]  response_timeout;
      logic [RETRY_W-1:0] idle_retry_limit;
      logic [BYTE_W-1:0]  wake_clock_bytes;
   } msbs_csr_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [COUNT_W-1:0] byte_count;
      logic [WAIT_W-1:0]  wait_count;
      logic [RETRY_W-1:0] retry_count;
      logic [BLOCK_W-1:0] block_address;
   } msbs_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  mosi_byte;
      logic               select_active;
      logic               read_valid;
      logic [BYTE_W-1:0]  read_byte;
      logic               write_taken;
      logic               busy_res;
      logic               done_res;
      logic [ERROR_W-1:0] error_code;
   } msbs_result_type;

endpackage

[src/msbs_if.sv]
// Request and response channel interfaces of the card sequencer.
// Depends on msbs_pkg.
interface msbs_req_if import msbs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BLOCK_W-1:0]  block_index;
   logic [BYTE_W-1:0]   miso_byte;
   logic [BYTE_W-1:0]   write_byte;

   modport source (output valid, output opcode, output block_index,
                   output miso_byte, output write_byte, input ready);
   modport sink   (input valid, input opcode, input block_index,
                   input miso_byte, input write_byte, output ready);
endinterface

interface msbs_rsp_if import msbs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  mosi_byte;
   logic               select_active;
   logic               read_valid;
   logic [BYTE_W-1:0]  read_byte;
   logic               write_taken;
   logic               busy_res;
   logic               done_res;
   logic [ERROR_W-1:0] error_code;

   modport source (output valid, output mosi_byte, output select_active,
                   output read_valid, output read_byte, output write_taken,
                   output busy_res, output done_res, output error_code, input ready);
   modport sink   (input valid, input mosi_byte, input select_active,
                   input read_valid, input read_byte, input write_taken,
                   input busy_res, input done_res, input error_code, output ready);
endinterface

[src/mmc_spi_block_sequencer.sv]
// Top level of the SPI-mode card sequencer: state, result register, handshakes.
// Depends on msbs_pkg, msbs_if, msbs_csr and msbs_step.
//
// One request beat is one SPI byte exchange (or a start of init, read or write) and
// gives exactly one response beat, in the cycle after acceptance. Unless stalled, a
// new beat is taken every clock: the phase state and the response register update
// together, and the request side stays ready whenever the response register is empty
// or being drained, so throughput is one beat per cycle. Blocks are 512 bytes.
// Configuration writes take effect on the next clock and belong to idle periods.
module mmc_spi_block_sequencer import msbs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   msbs_req_if.sink               req_if,
   msbs_rsp_if.source             rsp_if,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   msbs_csr_type    csr;
   msbs_state_type  state_ff;
   msbs_state_type  state_in;
   msbs_result_type rsp_ff;
   msbs_result_type rsp_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            accept;

   msbs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr_out          (csr)
   );

   msbs_step u_step (
      .state_cur    (state_ff),
      .csr          (csr),
      .opcode       (req_if.opcode),
      .block_index  (req_if.block_index),
      .miso_byte    (req_if.miso_byte),
      .write_byte   (req_if.write_byte),
      .state_next   (state_in),
      .result       (rsp_in)
   );

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{phase: PH_IDLE, default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.mosi_byte     = rsp_ff.mosi_byte;
   assign rsp_if.select_active = rsp_ff.select_active;
   assign rsp_if.read_valid    = rsp_ff.read_valid;
   assign rsp_if.read_byte     = rsp_ff.read_byte;
   assign rsp_if.write_taken   = rsp_ff.write_taken;
   assign rsp_if.busy_res      = rsp_ff.busy_res;
   assign rsp_if.done_res      = rsp_ff.done_res;
   assign rsp_if.error_code    = rsp_ff.error_code;

endmodule

[src/msbs_csr.sv]
// Configuration registers of the card sequencer.
// Depends on msbs_pkg.
module msbs_csr import msbs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output msbs_csr_type           csr_out
);

   msbs_csr_type csr_ff;
   msbs_csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RESPONSE_TIMEOUT: csr_in.response_timeout = csr_write_data[WAIT_W-1:0];
            CSR_IDLE_RETRY_LIMIT: csr_in.idle_retry_limit = csr_write_data[RETRY_W-1:0];
            CSR_WAKE_CLOCK_BYTES: csr_in.wake_clock_bytes = csr_write_data[BYTE_W-1:0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.response_timeout <= 16'hFFFF;
         csr_ff.idle_retry_limit <= 8'hFF;
         csr_ff.wake_clock_bytes <= 8'd10;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr_out = csr_ff;

endmodule

[src/msbs_step.sv]
// Next-phase and result logic for one exchange beat of the card sequencer.
// Depends on msbs_pkg.
module msbs_step import msbs_pkg::*; (
   input  msbs_state_type      state_cur,
   input  msbs_csr_type        csr,
   input  logic [OPCODE_W-1:0] opcode,
   input  logic [BLOCK_W-1:0]  block_index,
   input  logic [BYTE_W-1:0]   miso_byte,
   input  logic [BYTE_W-1:0]   write_byte,
   output msbs_state_type      state_next,
   output msbs_result_type     result
);

   function automatic msbs_state_type go(msbs_state_type s, logic [PHASE_W-1:0] ph);
      msbs_state_type r;
      r            = s;
      r.phase      = ph;
      r.byte_count = '0;
      r.wait_count = '0;
      return r;
   endfunction

   msbs_state_type       nxt;
   logic                 fail;
   logic [ERROR_W-1:0]   err;
   logic                 rvalid;
   logic [WAIT_W-1:0]    poll_count;
   logic                 expired;
   logic [COUNT_W-1:0]   count_inc;
   logic [31:0]          addr;
   logic [BYTE_W-1:0]    mosi;
   logic                 sel;
   logic                 taken;

   assign poll_count = state_cur.wait_count + WAIT_W'(1);
   assign expired    = poll_count >= csr.response_timeout;
   assign count_inc  = state_cur.byte_count + COUNT_W'(1);

   always_comb begin
      nxt    = state_cur;
      fail   = 1'b0;
      err    = ERR_OK;
      rvalid = 1'b0;
      if (opcode != OP_EXCHANGE) begin
         nxt.retry_count = '0;
         if (opcode == OP_INIT) begin
            nxt = go(nxt, PH_WAKE);
         end else begin
            nxt.block_address = block_index;
            nxt = go(nxt, (opcode == OP_READ) ? PH_CMD17 : PH_CMD24);
         end
      end else begin
         unique case (state_cur.phase) inside
            PH_CMD0, PH_CMD1, PH_CMD16, PH_CMD17, PH_CMD24: begin
               nxt.byte_count = count_inc;
               if (count_inc >= CMD_BYTES) nxt = go(nxt, state_cur.phase + PHASE_W'(1));
            end
            PH_WAKE: begin
               nxt.byte_count = count_inc;
               if (count_inc >= COUNT_W'(csr.wake_clock_bytes)) nxt = go(nxt, PH_CMD0);
            end
            PH_R0: begin
               if (miso_byte == R1_IDLE) begin
                  nxt = go(nxt, PH_CMD1);
                  nxt.retry_count = RETRY_W'(1);
               end else begin
                  nxt.wait_count = poll_count;
                  if (expired) begin
                     fail = 1'b1;
                     err  = ERR_NO_IDLE;
                  end
               end
            end
            PH_R1: begin
               if (miso_byte == R1_READY) begin
                  nxt = go(nxt, PH_GAP);
               end else begin
                  nxt.wait_count = poll_count;
                  if (expired) begin
                     if (state_cur.retry_count >= csr.idle_retry_limit) begin
                        fail = 1'b1;
                        err  = ERR_RETRY_LIMIT;
                     end else begin
                        nxt = go(nxt, PH_CMD1);
                        nxt.retry_count = state_cur.retry_count + RETRY_W'(1);
                     end
                  end
               end
            end
            PH_GAP: nxt = go(nxt, PH_CMD16);
            PH_R16: begin
               if (miso_byte == R1_READY) begin
                  fail = 1'b1;
               end else begin
                  nxt.wait_count = poll_count;
                  if (expired) begin
                     fail = 1'b1;
                     err  = ERR_CMD_TIMEOUT;
                  end
               end
            end
            PH_R17, PH_R24: begin
               if (miso_byte == R1_READY) begin
                  nxt = go(nxt, (state_cur.phase == PH_R17) ? PH_TOKW : PH_WTOK);
               end else begin
                  nxt.wait_count = poll_count;
                  if (expired) begin
                     fail = 1'b1;
                     err  = ERR_CMD_TIMEOUT;
                  end
               end
            end
            PH_TOKW: begin
               if (miso_byte == DATA_TOKEN) begin
                  nxt = go(nxt, PH_RDATA);
               end else begin
                  nxt.wait_count = poll_count;
                  if (expired) begin
                     fail = 1'b1;
                     err  = ERR_NO_TOKEN;
                  end
               end
            end
            PH_RDATA: begin
               rvalid         = 1'b1;
               nxt.byte_count = count_inc;
               if (count_inc >= DATA_BYTES) nxt = go(nxt, PH_RCRC);
            end
            PH_RCRC: begin
               nxt.byte_count = count_inc;
               if (count_inc >= CRC_BYTES) nxt = go(nxt, PH_RTAIL);
            end
            PH_RTAIL: fail = 1'b1;
            PH_WTOK:  nxt = go(nxt, PH_WDATA);
            PH_WDATA: begin
               nxt.byte_count = count_inc;
               if (count_inc >= DATA_BYTES) nxt = go(nxt, PH_WCRC);
            end
            PH_WCRC: begin
               nxt.byte_count = count_inc;
               if (count_inc >= CRC_BYTES) nxt = go(nxt, PH_WRESP);
            end
            PH_WRESP: begin
               fail = 1'b1;
               err  = (miso_byte[3:0] == RESP_MASKED_OK) ? ERR_OK : ERR_REJECTED;
            end
            default: nxt.phase = PH_IDLE;
         endcase
      end
      if (fail) nxt = go(nxt, PH_IDLE);
   end

   assign addr = 32'(nxt.block_address) << BLOCK_SHIFT;

   always_comb begin
      mosi  = IDLE_BYTE;
      sel   = 1'b1;
      taken = 1'b0;
      case (nxt.phase) inside
         PH_CMD0: begin
            if (nxt.byte_count == COUNT_W'(0))      mosi = CMD0_CODE;
            else if (nxt.byte_count == COUNT_W'(5)) mosi = CMD0_CRC;
            else                                    mosi = ZERO_BYTE;
         end
         PH_CMD1: begin
            if (nxt.byte_count == COUNT_W'(0))      mosi = CMD1_CODE;
            else if (nxt.byte_count == COUNT_W'(5)) mosi = IDLE_BYTE;
            else                                    mosi = ZERO_BYTE;
         end
         PH_CMD16: begin
            if (nxt.byte_count == COUNT_W'(0))      mosi = CMD16_CODE;
            else if (nxt.byte_count == COUNT_W'(3)) mosi = LEN_HI_BYTE;
            else if (nxt.byte_count == COUNT_W'(5)) mosi = IDLE_BYTE;
            else                                    mosi = ZERO_BYTE;
         end
         PH_CMD17, PH_CMD24: begin
            case (nxt.byte_count)
               COUNT_W'(0): mosi = (nxt.phase == PH_CMD17) ? CMD17_CODE : CMD24_CODE;
               COUNT_W'(1): mosi = addr[31:24];
               COUNT_W'(2): mosi = addr[23:16];
               COUNT_W'(3): mosi = addr[15:8];
               COUNT_W'(4): mosi = addr[7:0];
               default:     mosi = IDLE_BYTE;
            endcase
         end
         PH_IDLE, PH_WAKE, PH_GAP, PH_RTAIL: sel = 1'b0;
         PH_WTOK: mosi = DATA_TOKEN;
         PH_WDATA: begin
            mosi  = write_byte;
            taken = 1'b1;
         end
         default: mosi = IDLE_BYTE;
      endcase
   end

   assign state_next             = nxt;
   assign result.mosi_byte       = mosi;
   assign result.select_active   = sel;
   assign result.read_valid      = rvalid;
   assign result.read_byte       = rvalid ? miso_byte : ZERO_BYTE;
   assign result.write_taken     = taken;
   assign result.busy_res        = nxt.phase != PH_IDLE;
   assign result.done_res        = fail;
   assign result.error_code      = err;

endmodule

[src/msbs_checker.sv]
// Port-level checks of the card sequencer, bound to the top level.
// Depends on msbs_pkg and the assertion macro header.
`include "mmc_spi_block_sequencer_macros.svh"

module msbs_checker import msbs_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BYTE_W-1:0]  mosi_byte,
   input logic               select_active,
   input logic               read_valid,
   input logic               write_taken,
   input logic               busy_res,
   input logic               done_res,
   input logic [ERROR_W-1:0] error_code
);

   `MSBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(mosi_byte) && $stable(done_res) && $stable(error_code), "stalled response beat changed")
   `MSBS_ASSERT_NOW(a_done_release, clock, reset, rsp_valid && done_res, !busy_res && !select_active && mosi_byte == IDLE_BYTE, "completion did not release the card")
   `MSBS_ASSERT_NOW(a_error_on_done, clock, reset, rsp_valid && error_code != ERR_OK, done_res, "error code outside a completion beat")
   `MSBS_ASSERT_NOW(a_data_busy, clock, reset, rsp_valid && (read_valid || write_taken), busy_res && select_active && !done_res, "data beat outside an active transfer")

endmodule

bind mmc_spi_block_sequencer msbs_checker u_msbs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .mosi_byte     (rsp_if.mosi_byte),
   .select_active (rsp_if.select_active),
   .read_valid    (rsp_if.read_valid),
   .write_taken   (rsp_if.write_taken),
   .busy_res      (rsp_if.busy_res),
   .done_res      (rsp_if.done_res),
   .error_code    (rsp_if.error_code)
);
